FILE: hw/rtl/bsl_pkg.sv
// ----------------------------------------------------------------------------
// bsl_pkg
// Request, result and control types shared by the sequential list core and
// its storage cells.
// ----------------------------------------------------------------------------
package bsl_pkg;

  typedef enum logic [2:0] {
    REQ_INSERT_AT = 3'd0,
    REQ_SORTED    = 3'd1,
    REQ_REMOVE_AT = 3'd2,
    REQ_FIND      = 3'd3,
    REQ_REPLACE   = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_FULL     = 3'd1,
    STS_EMPTY    = 3'd2,
    STS_BADPOS   = 3'd3,
    STS_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    MODE_HOLD = 2'd0,
    MODE_LOAD = 2'd1,
    MODE_UP   = 2'd2,
    MODE_DOWN = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_APPLY = 2'b10
  } state_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [5:0]  position;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    status_e    status;
    logic [5:0] result_position;
    logic [5:0] entry_count;
    logic       is_empty;
    logic       is_full;
  } rsp_t;

  typedef struct packed {
    logic  cmp_en;
    mode_e mode;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/bsl_cell.sv
// ----------------------------------------------------------------------------
// bsl_cell
// One list entry: holds a word, loads a new value or takes a neighbor's word
// on a shift, and registers its compare flags against the request value.
// ----------------------------------------------------------------------------
module bsl_cell #(
  parameter int unsigned ElemWidth = 32
) (
  input  logic                 clk_i,
  input  bsl_pkg::cell_ctrl_t  ctrl_i,
  input  logic [ElemWidth-1:0] val_i,
  input  logic [ElemWidth-1:0] left_i,
  input  logic [ElemWidth-1:0] right_i,
  output logic [ElemWidth-1:0] data_o,
  output logic                 ge_o,
  output logic                 eq_o
);

  logic [ElemWidth-1:0] data_q, data_d;
  logic                 ge_q, eq_q;

  always_comb begin
    case (ctrl_i.mode)
      bsl_pkg::MODE_LOAD: data_d = val_i;
      bsl_pkg::MODE_UP:   data_d = left_i;
      bsl_pkg::MODE_DOWN: data_d = right_i;
      default:            data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (ctrl_i.cmp_en) begin
      ge_q <= $signed(data_q) >= $signed(val_i);
      eq_q <= data_q == val_i;
    end
  end

  assign data_o = data_q;
  assign ge_o   = ge_q;
  assign eq_o   = eq_q;

endmodule

FILE: hw/rtl/bounded_sequential_list_core.sv
// ----------------------------------------------------------------------------
// bounded_sequential_list_core
// Fixed-capacity list of signed words with insert, sorted insert, remove,
// find and replace requests, built as a row of entry cells.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low. In the accept
// cycle every cell compares its entry with the request value; in the next
// cycle (busy_o high) the match is priority-picked and the row shifts or
// loads in one step. The result appears on rsp_o with rsp_valid_o for one
// cycle, registered at the end of the busy_o cycle, and cannot be stalled.
// A request is a compare pass and then a shift pass over the cell row; a
// new request may be accepted in the cycle the previous result shows.
module bounded_sequential_list_core #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  bsl_pkg::req_t req_i,
  output logic          busy_o,
  output logic          rsp_valid_o,
  output bsl_pkg::rsp_t rsp_o
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = ((CW > 6) ? CW : 6) + 1;

  bsl_pkg::state_e state_q, state_d;
  bsl_pkg::req_t   req_q;
  logic [CW-1:0]   count_q, count_d;
  logic            rsp_valid_q;
  bsl_pkg::rsp_t   rsp_q, rsp_d;

  logic                  accept;
  logic [95:0]           in_ext, req_ext;
  logic [ELEM_WIDTH-1:0] in_val, req_val;
  logic [ELEM_WIDTH-1:0] cell_val;
  logic [ELEM_WIDTH-1:0] data   [CAPACITY];
  logic [CAPACITY-1:0]   ge_raw, eq_raw, valid, ge_f, eq_f, ge_oh, eq_oh;
  logic [CMPW-1:0]       ge_idx, eq_idx, pos_x, cnt_x, k;
  logic                  do_ins, do_rem, do_rep;
  bsl_pkg::cell_ctrl_t   ctrl [CAPACITY];

  assign accept   = start_i && (state_q == bsl_pkg::ST_IDLE);
  assign busy_o   = (state_q == bsl_pkg::ST_APPLY);
  assign in_ext   = {{64{req_i.value[31]}}, req_i.value};
  assign req_ext  = {{64{req_q.value[31]}}, req_q.value};
  assign in_val   = in_ext[ELEM_WIDTH-1:0];
  assign req_val  = req_ext[ELEM_WIDTH-1:0];
  assign cell_val = accept ? in_val : req_val;

  // flags, lowest match
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid[i] = CMPW'(i) < CMPW'(count_q);
    end
    ge_f  = ge_raw & valid;
    eq_f  = eq_raw & valid;
    ge_oh = ge_f & (~ge_f + CAPACITY'(1));
    eq_oh = eq_f & (~eq_f + CAPACITY'(1));
    ge_idx = CMPW'(count_q);
    eq_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (ge_oh[i]) ge_idx = CMPW'(i);
      if (eq_oh[i]) eq_idx = CMPW'(i);
    end
  end

  always_comb begin
    pos_x   = CMPW'(req_q.position);
    cnt_x   = CMPW'(count_q);
    k       = pos_x - CMPW'(1);
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    do_rep  = 1'b0;
    count_d = count_q;
    rsp_d.status          = bsl_pkg::STS_OK;
    rsp_d.result_position = '0;
    case (req_q.req_type)
      bsl_pkg::REQ_INSERT_AT: begin
        if (count_q == CW'(CAPACITY)) begin
          rsp_d.status = bsl_pkg::STS_FULL;
        end else if (pos_x == '0 || pos_x > cnt_x + CMPW'(1)) begin
          rsp_d.status = bsl_pkg::STS_BADPOS;
        end else begin
          do_ins = 1'b1;
        end
      end
      bsl_pkg::REQ_SORTED: begin
        k = ge_idx;
        if (count_q == CW'(CAPACITY)) begin
          rsp_d.status = bsl_pkg::STS_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      bsl_pkg::REQ_REMOVE_AT: begin
        if (count_q == '0) begin
          rsp_d.status = bsl_pkg::STS_EMPTY;
        end else if (pos_x == '0 || pos_x > cnt_x) begin
          rsp_d.status = bsl_pkg::STS_BADPOS;
        end else begin
          do_rem = 1'b1;
        end
      end
      bsl_pkg::REQ_FIND: begin
        k = eq_idx;
        if (eq_f == '0) begin
          rsp_d.status = bsl_pkg::STS_NOTFOUND;
        end
      end
      bsl_pkg::REQ_REPLACE: begin
        if (count_q == '0) begin
          rsp_d.status = bsl_pkg::STS_EMPTY;
        end else if (pos_x == '0 || pos_x > cnt_x) begin
          rsp_d.status = bsl_pkg::STS_BADPOS;
        end else begin
          do_rep = 1'b1;
        end
      end
      default: begin
        rsp_d.status = bsl_pkg::STS_BADPOS;
      end
    endcase
    if (do_ins) count_d = count_q + CW'(1);
    if (do_rem) count_d = count_q - CW'(1);
    if (rsp_d.status == bsl_pkg::STS_OK) begin
      rsp_d.result_position = 6'(k + CMPW'(1));
    end
    rsp_d.entry_count = 6'(count_d);
    rsp_d.is_empty    = (count_d == '0);
    rsp_d.is_full     = (count_d == CW'(CAPACITY));
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctrl[i].cmp_en = accept;
      ctrl[i].mode   = bsl_pkg::MODE_HOLD;
      if (busy_o) begin
        if ((do_ins || do_rep) && CMPW'(i) == k) begin
          ctrl[i].mode = bsl_pkg::MODE_LOAD;
        end else if (do_ins && CMPW'(i) > k) begin
          ctrl[i].mode = bsl_pkg::MODE_UP;
        end else if (do_rem && CMPW'(i) >= k && i < CAPACITY - 1) begin
          ctrl[i].mode = bsl_pkg::MODE_DOWN;
        end
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ELEM_WIDTH-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = data[g+1];
    end
    bsl_cell #(
      .ElemWidth (ELEM_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[g]),
      .val_i   (cell_val),
      .left_i  (left),
      .right_i (right),
      .data_o  (data[g]),
      .ge_o    (ge_raw[g]),
      .eq_o    (eq_raw[g])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bsl_pkg::ST_IDLE:  if (start_i) state_d = bsl_pkg::ST_APPLY;
      bsl_pkg::ST_APPLY: state_d = bsl_pkg::ST_IDLE;
      default:           state_d = bsl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsl_pkg::ST_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= busy_o;
      if (busy_o) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i;
    if (busy_o) rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
